### hdl/bsp_pkg.sv
// bsp_pkg: shared widths, opcodes and the result record of the binary search probe counter
// no dependencies; used by every module of the block
package bsp_pkg;

    localparam int KEY_W   = 32;
    localparam int INDEX_W = 10;
    localparam int CFG_W   = 11;
    localparam int COUNT_W = 4;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic [COUNT_W-1:0] probe_count;
        logic               found;
    } t_result;

endpackage

### hdl/bsp_table.sv
// bsp_table: key table memory with one write port and one registered read port
// depends on bsp_pkg for the key width
module bsp_table #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_wr_addr,
    input  logic [bsp_pkg::KEY_W-1:0]     i_wr_data,
    input  logic                          i_rd_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_rd_addr,
    output logic [bsp_pkg::KEY_W-1:0]     o_rd_data
);

    logic [bsp_pkg::KEY_W-1:0] r_mem [TABLE_DEPTH];
    logic [bsp_pkg::KEY_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/bsp_ctrl.sv
// bsp_ctrl: search sequencer, bound update from an equal and a less-than compare, and result register
// depends on bsp_pkg; drives the read port of bsp_table
module bsp_ctrl #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [bsp_pkg::KEY_W-1:0]  i_key,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]  i_count,
    output logic                              o_busy,
    output logic                              o_rd_en,
    output logic [$clog2(TABLE_DEPTH)-1:0]    o_rd_addr,
    input  logic signed [bsp_pkg::KEY_W-1:0]  i_rd_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output bsp_pkg::t_result                  o_result
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_COMPARE,
        S_FINISH
    } t_state;

    t_state                           r_state;
    logic [CW-1:0]                    r_lo;
    logic [CW-1:0]                    r_hi;
    logic [AW-1:0]                    r_mid;
    logic signed [bsp_pkg::KEY_W-1:0] r_key;
    logic [bsp_pkg::COUNT_W-1:0]      r_probes;
    logic                             r_found;
    logic                             r_out_valid;
    bsp_pkg::t_result                 r_result;

    logic [CW:0]   n_sum;
    logic [AW-1:0] n_mid;
    logic          n_nonempty;

    assign n_sum      = {1'b0, r_lo} + {1'b0, r_hi} - {{CW{1'b0}}, 1'b1};
    assign n_mid      = n_sum[AW:1];
    assign n_nonempty = r_lo < r_hi;

    assign o_rd_en   = (r_state == S_CHECK) && n_nonempty;
    assign o_rd_addr = n_mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_FINISH) && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_lo     <= '0;
                        r_hi     <= i_count;
                        r_key    <= i_key;
                        r_probes <= '0;
                        r_found  <= 1'b0;
                        r_state  <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (n_nonempty) begin
                        r_mid   <= n_mid;
                        r_state <= S_COMPARE;
                    end else begin
                        r_state <= S_FINISH;
                    end
                end
                S_COMPARE: begin
                    r_probes <= r_probes + 1'b1;
                    if (r_key == i_rd_data) begin
                        r_found <= 1'b1;
                        r_state <= S_FINISH;
                    end else begin
                        if (r_key < i_rd_data) begin
                            r_hi <= CW'(r_mid);
                        end else begin
                            r_lo <= CW'(r_mid) + 1'b1;
                        end
                        r_state <= S_CHECK;
                    end
                end
                S_FINISH: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_result.probe_count <= r_probes;
                        r_result.found       <= r_found;
                        r_state              <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

### hdl/binary_search_probe_counter.sv
// binary_search_probe_counter: top level with input decode, table size register and ports
// depends on bsp_pkg, bsp_table and bsp_ctrl
//
// A write item stores one key in the table and gives no result; writes at a position not
// below TABLE_DEPTH are dropped. A search item runs a binary search over the first
// entries_in_use positions (clamped to TABLE_DEPTH) and gives one result with the probe
// count and a found flag. Each probe issues a read on the table's registered read port,
// then does the compare and bound update; the input stays stalled for the whole search and
// any wait for the result register to drain. Writes are taken while a result waits.
// The table needs no clearing after reset, but entries must be written before they are
// searched. The size register is written through its own channel, always ready.
module binary_search_probe_counter #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bsp_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_opcode,
    input  logic [bsp_pkg::INDEX_W-1:0]       i_entry_index,
    input  logic signed [bsp_pkg::KEY_W-1:0]  i_entry_value,
    input  logic signed [bsp_pkg::KEY_W-1:0]  i_search_key,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [bsp_pkg::COUNT_W-1:0]       o_probe_count,
    output logic                              o_found
);

    localparam int          AW      = $clog2(TABLE_DEPTH);
    localparam int          CW      = $clog2(TABLE_DEPTH + 1);
    localparam logic [31:0] DEPTH32 = 32'(TABLE_DEPTH);

    logic [bsp_pkg::CFG_W-1:0] r_entries_in_use;

    logic                             w_accept;
    logic                             w_busy;
    logic                             w_wr_en;
    logic [31:0]                      w_cfg32;
    logic [CW-1:0]                    w_count;
    logic                             w_rd_en;
    logic [AW-1:0]                    w_rd_addr;
    logic signed [bsp_pkg::KEY_W-1:0] w_rd_data;
    bsp_pkg::t_result                 w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries_in_use <= '0;
        end else if (i_cfg_valid) begin
            r_entries_in_use <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_wr_en  = w_accept && (i_opcode == bsp_pkg::OP_WRITE)
                      && (32'(i_entry_index) < DEPTH32);
    assign w_cfg32  = 32'(r_entries_in_use);
    assign w_count  = (w_cfg32 > DEPTH32) ? CW'(DEPTH32) : CW'(w_cfg32);

    bsp_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_table (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(AW'(i_entry_index)),
        .i_wr_data(i_entry_value),
        .i_rd_en  (w_rd_en),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_data)
    );

    bsp_ctrl #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept && (i_opcode == bsp_pkg::OP_SEARCH)),
        .i_key      (i_search_key),
        .i_count    (w_count),
        .o_busy     (w_busy),
        .o_rd_en    (w_rd_en),
        .o_rd_addr  (w_rd_addr),
        .i_rd_data  (w_rd_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_result   (w_result)
    );

    assign o_in_stall    = w_busy;
    assign o_probe_count = w_result.probe_count;
    assign o_found       = w_result.found;

endmodule

### hdl/bsp_checker.sv
// bsp_checker: port-level assertions for binary_search_probe_counter
// depends on bsp_pkg; attached to the top level by the bind below
module bsp_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        i_opcode,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [bsp_pkg::COUNT_W-1:0] o_probe_count,
    input logic                        o_found
);

    logic w_accept;
    assign w_accept = i_in_valid && !o_in_stall;

    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_opcode == bsp_pkg::OP_SEARCH) |=> o_in_stall)
        else $error("search item did not make the block busy");

    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_opcode == bsp_pkg::OP_WRITE) |=> !o_in_stall)
        else $error("write item left the block busy");

    a_found_probed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> o_probe_count != '0)
        else $error("found without any probe");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_probe_count) && $stable(o_found))
        else $error("stalled result item changed");

endmodule

bind binary_search_probe_counter bsp_checker u_bsp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_opcode     (i_opcode),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_probe_count(o_probe_count),
    .o_found      (o_found)
);
